FILE: hw/rtl/radar_measurement_jacobian_core_assert.svh
// Assertion macros shared by the radar Jacobian checkers.
// Needs nothing else; include by bare file name.
`ifndef RADAR_MEASUREMENT_JACOBIAN_CORE_ASSERT_SVH
`define RADAR_MEASUREMENT_JACOBIAN_CORE_ASSERT_SVH

// same-cycle implication
`define RMJ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RMJ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/rmj_pkg.sv
// Package for the radar measurement Jacobian core: widths, latencies
// and the small arithmetic helpers. No dependencies.
package rmj_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int VAL_W      = 32;
	localparam int RANGE_W    = 18;
	localparam int CFG_W      = 16;
	localparam logic [CFG_W-1:0] CFG_RESET = 16'd7;

	localparam int SH         = 32 - FRAC_BITS;
	localparam int RAD_W      = 64;
	localparam int SQRT_STEPS = RAD_W / 2;
	localparam int QW         = 33;
	localparam int DIV_LAT    = QW + 1;
	localparam int PROD_W     = QW + 64;
	localparam int RNUM_W     = PROD_W - SH;
	localparam int BNUM_W     = VAL_W + 2 * FRAC_BITS;
	localparam int RMAG_W     = QW - SH;

	function automatic logic [VAL_W-1:0] mag32(input logic [VAL_W-1:0] x);
		mag32 = x[VAL_W-1] ? (~x + 32'd1) : x;
	endfunction

	// number of leading zero bit pairs
	function automatic logic [4:0] lead_pairs(input logic [RAD_W-1:0] s);
		logic [4:0] k;
		k = '0;
		for (int i = 0; i < SQRT_STEPS; i++) begin
			if (s[2*i +: 2] != 2'b00) begin
				k = 5'(SQRT_STEPS - 1 - i);
			end
		end
		lead_pairs = k;
	endfunction

	function automatic logic [VAL_W-1:0] sat32(input logic big, input logic [QW-1:0] q,
			input logic neg);
		logic [VAL_W-1:0] r;
		if (neg) begin
			if (big || q > {1'b0, 32'h8000_0000}) begin
				r = 32'h8000_0000;
			end else begin
				r = ~q[VAL_W-1:0] + 32'd1;
			end
		end else begin
			if (big || q > {1'b0, 32'h7fff_ffff}) begin
				r = 32'h7fff_ffff;
			end else begin
				r = q[VAL_W-1:0];
			end
		end
		sat32 = r;
	endfunction

	function automatic logic [RANGE_W-1:0] sgn18(input logic [RMAG_W-1:0] m, input logic neg);
		logic [RANGE_W-1:0] e;
		e = RANGE_W'(m);
		sgn18 = neg ? (~e + 18'd1) : e;
	endfunction

endpackage

FILE: hw/rtl/rmj_if.sv
// Channel interfaces of the radar Jacobian core: state in, Jacobian out,
// threshold write. Depends on rmj_pkg.
interface rmj_vec_if;
	import rmj_pkg::*;
	logic valid;
	logic ready;
	logic signed [VAL_W-1:0] pos_x;
	logic signed [VAL_W-1:0] pos_y;
	logic signed [VAL_W-1:0] vel_x;
	logic signed [VAL_W-1:0] vel_y;
	modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
	modport sink (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface rmj_jac_if;
	import rmj_pkg::*;
	logic valid;
	logic ready;
	logic signed [RANGE_W-1:0] range_by_px;
	logic signed [RANGE_W-1:0] range_by_py;
	logic signed [VAL_W-1:0] bearing_by_px;
	logic signed [VAL_W-1:0] bearing_by_py;
	logic signed [VAL_W-1:0] rate_by_px;
	logic signed [VAL_W-1:0] rate_by_py;
	logic div_error;
	modport source (output valid, range_by_px, range_by_py, bearing_by_px, bearing_by_py,
		rate_by_px, rate_by_py, div_error, input ready);
	modport sink (input valid, range_by_px, range_by_py, bearing_by_px, bearing_by_py,
		rate_by_px, rate_by_py, div_error, output ready);
endinterface

interface rmj_cfg_if;
	import rmj_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_W-1:0] min_sq_range;
	modport source (output valid, min_sq_range, input ready);
	modport sink (input valid, min_sq_range, output ready);
endinterface

FILE: hw/rtl/rmj_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on rmj_pkg.
module rmj_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [rmj_pkg::RAD_W-1:0] radicand,
	output logic                      out_valid,
	output logic [rmj_pkg::SQRT_STEPS-1:0] root
);
	import rmj_pkg::*;

	localparam int RW = SQRT_STEPS + 2;

	logic [RAD_W-1:0]      rad_s  [1:SQRT_STEPS];
	logic [RW-1:0]         rem_s  [1:SQRT_STEPS];
	logic [SQRT_STEPS-1:0] root_s [1:SQRT_STEPS];
	logic                  vld_s  [1:SQRT_STEPS];

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
		logic [RAD_W-1:0]      rad_in;
		logic [RW-1:0]         rem_in;
		logic [SQRT_STEPS-1:0] root_in;
		logic                  vld_in;
		logic [RW+1:0]         cur;
		logic [RW+1:0]         trial;
		logic                  take;

		if (i == 0) begin : g_first
			assign rad_in  = radicand;
			assign rem_in  = '0;
			assign root_in = '0;
			assign vld_in  = in_valid;
		end else begin : g_next
			assign rad_in  = rad_s[i];
			assign rem_in  = rem_s[i];
			assign root_in = root_s[i];
			assign vld_in  = vld_s[i];
		end

		assign cur   = {rem_in, rad_in[RAD_W-1 -: 2]};
		assign trial = (RW+2)'({root_in, 2'b01});
		assign take  = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i+1]  <= rad_in << 2;
				rem_s[i+1]  <= take ? RW'(cur - trial) : RW'(cur);
				root_s[i+1] <= {root_in[SQRT_STEPS-2:0], take};
			end
		end
	end

	assign out_valid = vld_s[SQRT_STEPS];
	assign root      = root_s[SQRT_STEPS];

endmodule

FILE: hw/rtl/rmj_div.sv
// Pipelined restoring divider, one quotient bit per stage after an
// overflow-check stage. Depends on rmj_pkg.
module rmj_div #(
	parameter int NW = 64,
	parameter int DW = 32,
	parameter int QW = rmj_pkg::QW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          out_valid,
	output logic [QW-1:0] quot,
	output logic          ovf
);
	import rmj_pkg::*;

	localparam int HW = NW - QW;

	logic [DW-1:0] rem_s [1:QW+1];
	logic [QW-1:0] acc_s [1:QW+1];
	logic [DW-1:0] den_s [1:QW+1];
	logic          ovf_s [1:QW+1];
	logic          vld_s [1:QW+1];

	logic [DW+HW-1:0] hi_ext;
	logic [DW+HW-1:0] den_ext;

	assign hi_ext  = {{DW{1'b0}}, num[NW-1:QW]};
	assign den_ext = {{HW{1'b0}}, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[1] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[1] <= hi_ext[DW-1:0];
			acc_s[1] <= num[QW-1:0];
			den_s[1] <= den;
			ovf_s[1] <= hi_ext >= den_ext;
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_step
		logic [DW:0] tmp;
		logic [DW:0] diff;
		logic        ge;

		assign tmp  = {rem_s[j], acc_s[j][QW-1]};
		assign diff = tmp - {1'b0, den_s[j]};
		assign ge   = tmp >= {1'b0, den_s[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? diff[DW-1:0] : tmp[DW-1:0];
				acc_s[j+1] <= {acc_s[j][QW-2:0], ge};
				den_s[j+1] <= den_s[j];
				ovf_s[j+1] <= ovf_s[j];
			end
		end
	end

	assign out_valid = vld_s[QW+1];
	assign quot      = acc_s[QW+1];
	assign ovf       = ovf_s[QW+1];

endmodule

FILE: hw/rtl/rmj_delay.sv
// Enable-gated delay line carrying side data alongside the arithmetic units.
// Depends on rmj_pkg.
module rmj_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = rmj_pkg::DIV_LAT
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);
	import rmj_pkg::*;

	logic [WIDTH-1:0] data_s [1:DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			data_s[1] <= din;
		end
	end

	for (genvar i = 2; i <= DEPTH; i++) begin : g_tap
		always_ff @(posedge clk) begin
			if (en) begin
				data_s[i] <= data_s[i-1];
			end
		end
	end

	assign dout = data_s[DEPTH];

endmodule

FILE: hw/rtl/radar_measurement_jacobian_core.sv
// Top level of the radar measurement Jacobian core.
// Depends on rmj_pkg, rmj_if, rmj_sqrt, rmj_div, rmj_delay.
//
//  channel | dir | carries
//  --------+-----+------------------------------------------------
//  cfg     | in  | min_sq_range threshold write
//  vec     | in  | state item pos_x, pos_y, vel_x, vel_y
//  jac     | out | Jacobian item, six entries plus div_error
//
// One item per cycle while the output is not stalled; the pipeline is five front stages, a 32-stage
// square root, a 34-stage unit-fraction divider, two multiply stages, a
// 34-stage rate/bearing divider and the output register.
// Reset clears valid bits and loads the threshold with 7.
// The whole pipeline holds while the output item waits; vec.ready follows.
module radar_measurement_jacobian_core (
	input logic clk,
	input logic arst_n,
	rmj_cfg_if.sink   cfg,
	rmj_vec_if.sink   vec,
	rmj_jac_if.source jac
);
	import rmj_pkg::*;

	typedef struct packed {
		logic [VAL_W-1:0] mpk;
		logic [VAL_W-1:0] mqk;
		logic [VAL_W-1:0] mp;
		logic [VAL_W-1:0] mq;
		logic [63:0]      mt;
		logic [RAD_W-1:0] s;
		logic             nt;
		logic             np;
		logic             nq;
		logic             err;
	} side_a_t;

	typedef struct packed {
		logic [VAL_W-1:0] mp;
		logic [VAL_W-1:0] mq;
		logic [63:0]      mt;
		logic [RAD_W-1:0] s;
		logic             nt;
		logic             np;
		logic             nq;
		logic             err;
	} side_b_t;

	typedef struct packed {
		logic [RMAG_W-1:0] rx;
		logic [RMAG_W-1:0] ry;
		logic              nt;
		logic              np;
		logic              nq;
		logic              err;
	} side_c_t;

	logic en;
	logic [CFG_W-1:0] min_sq_range_q;

	assign en        = !jac.valid || jac.ready;
	assign vec.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sq_range_q <= CFG_RESET;
		end else if (cfg.valid && cfg.ready) begin
			min_sq_range_q <= cfg.min_sq_range;
		end
	end

	// front stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [VAL_W-1:0] mp_s1, mq_s1, mp_s2, mq_s2, mp_s3, mq_s3, mp_s4, mq_s4, mp_s5, mq_s5;
	logic np_s1, nq_s1, np_s2, nq_s2, np_s3, nq_s3, np_s4, nq_s4, np_s5, nq_s5;
	logic signed [VAL_W-1:0] p_s1, q_s1, vx_s1, vy_s1;
	logic [63:0] sqp_s2, sqq_s2;
	logic signed [63:0] xa_s2, xb_s2;
	logic [RAD_W-1:0] s_s3, s_s4, s_s5, s2_s5;
	logic signed [63:0] t_s3;
	logic err_s3, err_s4, err_s5;
	logic [63:0] mt_s4, mt_s5;
	logic nt_s4, nt_s5;
	logic [4:0] k_s4;
	logic [VAL_W-1:0] mpk_s5, mqk_s5;
	logic [RAD_W-1:0] s_sum;
	logic [RAD_W-1:0] thr;

	assign s_sum = sqp_s2 + sqq_s2;
	assign thr   = RAD_W'({min_sq_range_q, {FRAC_BITS{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= vec.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mp_s1  <= mag32(vec.pos_x);
			mq_s1  <= mag32(vec.pos_y);
			np_s1  <= vec.pos_x[VAL_W-1];
			nq_s1  <= vec.pos_y[VAL_W-1];
			p_s1   <= vec.pos_x;
			q_s1   <= vec.pos_y;
			vx_s1  <= vec.vel_x;
			vy_s1  <= vec.vel_y;

			sqp_s2 <= 64'(mp_s1) * 64'(mp_s1);
			sqq_s2 <= 64'(mq_s1) * 64'(mq_s1);
			xa_s2  <= 64'(vx_s1) * 64'(q_s1);
			xb_s2  <= 64'(vy_s1) * 64'(p_s1);
			mp_s2  <= mp_s1;
			mq_s2  <= mq_s1;
			np_s2  <= np_s1;
			nq_s2  <= nq_s1;

			s_s3   <= s_sum;
			t_s3   <= xa_s2 - xb_s2;
			err_s3 <= (s_sum == '0) || (s_sum < thr);
			mp_s3  <= mp_s2;
			mq_s3  <= mq_s2;
			np_s3  <= np_s2;
			nq_s3  <= nq_s2;

			mt_s4  <= t_s3[63] ? (~t_s3 + 64'sd1) : t_s3;
			nt_s4  <= t_s3[63];
			k_s4   <= lead_pairs(s_s3);
			s_s4   <= s_s3;
			err_s4 <= err_s3;
			mp_s4  <= mp_s3;
			mq_s4  <= mq_s3;
			np_s4  <= np_s3;
			nq_s4  <= nq_s3;

			s2_s5  <= s_s4 << {k_s4, 1'b0};
			mpk_s5 <= mp_s4 << k_s4;
			mqk_s5 <= mq_s4 << k_s4;
			s_s5   <= s_s4;
			mt_s5  <= mt_s4;
			nt_s5  <= nt_s4;
			err_s5 <= err_s4;
			mp_s5  <= mp_s4;
			mq_s5  <= mq_s4;
			np_s5  <= np_s4;
			nq_s5  <= nq_s4;
		end
	end

	// square root of the normalised sum
	logic v_r;
	logic [SQRT_STEPS-1:0] root_r;
	side_a_t sa_in, sa_r;

	assign sa_in = '{mpk: mpk_s5, mqk: mqk_s5, mp: mp_s5, mq: mq_s5, mt: mt_s5, s: s_s5,
		nt: nt_s5, np: np_s5, nq: nq_s5, err: err_s5};

	rmj_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.radicand  (s2_s5),
		.out_valid (v_r),
		.root      (root_r)
	);

	rmj_delay #(.WIDTH($bits(side_a_t)), .DEPTH(SQRT_STEPS)) u_dly_a (
		.clk  (clk),
		.en   (en),
		.din  (sa_in),
		.dout (sa_r)
	);

	// unit fractions
	logic v_u;
	logic [QW-1:0] up_q, uq_q;
	logic up_ovf, uq_ovf;
	side_b_t sb_in, sb_u;

	assign sb_in = '{mp: sa_r.mp, mq: sa_r.mq, mt: sa_r.mt, s: sa_r.s, nt: sa_r.nt,
		np: sa_r.np, nq: sa_r.nq, err: sa_r.err};

	rmj_div #(.NW(64), .DW(SQRT_STEPS), .QW(QW)) u_div_up (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_r),
		.num       ({sa_r.mpk, 32'b0}),
		.den       (root_r),
		.out_valid (v_u),
		.quot      (up_q),
		.ovf       (up_ovf)
	);

	rmj_div #(.NW(64), .DW(SQRT_STEPS), .QW(QW)) u_div_uq (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_r),
		.num       ({sa_r.mqk, 32'b0}),
		.den       (root_r),
		.out_valid (),
		.quot      (uq_q),
		.ovf       (uq_ovf)
	);

	rmj_delay #(.WIDTH($bits(side_b_t)), .DEPTH(DIV_LAT)) u_dly_b (
		.clk  (clk),
		.en   (en),
		.din  (sb_in),
		.dout (sb_u)
	);

	// multiply by |T|, split into two 32-bit halves
	logic [QW-1:0] upf, uqf;
	logic v_m1, v_m2;
	logic [QW+31:0] pul_m1, puh_m1, pql_m1, pqh_m1;
	logic [RMAG_W-1:0] rx_m1, ry_m1, rx_m2, ry_m2;
	logic [VAL_W-1:0] mp_m1, mq_m1;
	logic [RAD_W-1:0] s_m1, s_m2;
	logic nt_m1, np_m1, nq_m1, err_m1, nt_m2, np_m2, nq_m2, err_m2;
	logic [PROD_W-1:0] pu_sum, pq_sum;
	logic [RNUM_W-1:0] pu_num_m2, pq_num_m2;
	logic [BNUM_W-1:0] bp_num_m2, bq_num_m2;

	assign upf    = up_q | {QW{up_ovf}};
	assign uqf    = uq_q | {QW{uq_ovf}};
	assign pu_sum = {puh_m1, 32'b0} + PROD_W'(pul_m1);
	assign pq_sum = {pqh_m1, 32'b0} + PROD_W'(pql_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
		end else if (en) begin
			v_m1 <= v_u;
			v_m2 <= v_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pul_m1    <= (QW+32)'(upf) * (QW+32)'(sb_u.mt[31:0]);
			puh_m1    <= (QW+32)'(upf) * (QW+32)'(sb_u.mt[63:32]);
			pql_m1    <= (QW+32)'(uqf) * (QW+32)'(sb_u.mt[31:0]);
			pqh_m1    <= (QW+32)'(uqf) * (QW+32)'(sb_u.mt[63:32]);
			rx_m1     <= upf[QW-1:SH];
			ry_m1     <= uqf[QW-1:SH];
			mp_m1     <= sb_u.mp;
			mq_m1     <= sb_u.mq;
			s_m1      <= sb_u.s;
			nt_m1     <= sb_u.nt;
			np_m1     <= sb_u.np;
			nq_m1     <= sb_u.nq;
			err_m1    <= sb_u.err;

			pu_num_m2 <= pu_sum[PROD_W-1:SH];
			pq_num_m2 <= pq_sum[PROD_W-1:SH];
			bp_num_m2 <= {mp_m1, {(2*FRAC_BITS){1'b0}}};
			bq_num_m2 <= {mq_m1, {(2*FRAC_BITS){1'b0}}};
			rx_m2     <= rx_m1;
			ry_m2     <= ry_m1;
			s_m2      <= s_m1;
			nt_m2     <= nt_m1;
			np_m2     <= np_m1;
			nq_m2     <= nq_m1;
			err_m2    <= err_m1;
		end
	end

	// rate and bearing divisions by the squared range
	logic v_d;
	logic [QW-1:0] rpx_q, rpy_q, bpx_q, bpy_q;
	logic rpx_ovf, rpy_ovf, bpx_ovf, bpy_ovf;
	side_c_t sc_in, sc_d;

	assign sc_in = '{rx: rx_m2, ry: ry_m2, nt: nt_m2, np: np_m2, nq: nq_m2, err: err_m2};

	rmj_div #(.NW(RNUM_W), .DW(RAD_W), .QW(QW)) u_div_rpx (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_m2),
		.num       (pq_num_m2),
		.den       (s_m2),
		.out_valid (v_d),
		.quot      (rpx_q),
		.ovf       (rpx_ovf)
	);

	rmj_div #(.NW(RNUM_W), .DW(RAD_W), .QW(QW)) u_div_rpy (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_m2),
		.num       (pu_num_m2),
		.den       (s_m2),
		.out_valid (),
		.quot      (rpy_q),
		.ovf       (rpy_ovf)
	);

	rmj_div #(.NW(BNUM_W), .DW(RAD_W), .QW(QW)) u_div_bpx (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_m2),
		.num       (bq_num_m2),
		.den       (s_m2),
		.out_valid (),
		.quot      (bpx_q),
		.ovf       (bpx_ovf)
	);

	rmj_div #(.NW(BNUM_W), .DW(RAD_W), .QW(QW)) u_div_bpy (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_m2),
		.num       (bp_num_m2),
		.den       (s_m2),
		.out_valid (),
		.quot      (bpy_q),
		.ovf       (bpy_ovf)
	);

	rmj_delay #(.WIDTH($bits(side_c_t)), .DEPTH(DIV_LAT)) u_dly_c (
		.clk  (clk),
		.en   (en),
		.din  (sc_in),
		.dout (sc_d)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jac.valid <= 1'b0;
		end else if (en) begin
			jac.valid <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sc_d.err) begin
				jac.range_by_px   <= '0;
				jac.range_by_py   <= '0;
				jac.bearing_by_px <= '0;
				jac.bearing_by_py <= '0;
				jac.rate_by_px    <= '0;
				jac.rate_by_py    <= '0;
				jac.div_error     <= 1'b1;
			end else begin
				jac.range_by_px   <= sgn18(sc_d.rx, sc_d.np);
				jac.range_by_py   <= sgn18(sc_d.ry, sc_d.nq);
				jac.bearing_by_px <= sat32(bpx_ovf, bpx_q, !sc_d.nq);
				jac.bearing_by_py <= sat32(bpy_ovf, bpy_q, sc_d.np);
				jac.rate_by_px    <= sat32(rpx_ovf, rpx_q, sc_d.nq != sc_d.nt);
				jac.rate_by_py    <= sat32(rpy_ovf, rpy_q, sc_d.np == sc_d.nt);
				jac.div_error     <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/rmj_chk.sv
// Port-level checker for the radar Jacobian core, bound to the top level.
// Depends on rmj_pkg and radar_measurement_jacobian_core_assert.svh.
`include "radar_measurement_jacobian_core_assert.svh"

module rmj_chk (
	input logic clk,
	input logic arst_n,
	input logic vec_ready,
	input logic jac_valid,
	input logic jac_ready,
	input logic signed [rmj_pkg::RANGE_W-1:0] range_by_px,
	input logic signed [rmj_pkg::RANGE_W-1:0] range_by_py,
	input logic signed [rmj_pkg::VAL_W-1:0]   bearing_by_px,
	input logic signed [rmj_pkg::VAL_W-1:0]   bearing_by_py,
	input logic signed [rmj_pkg::VAL_W-1:0]   rate_by_px,
	input logic signed [rmj_pkg::VAL_W-1:0]   rate_by_py,
	input logic div_error
);
	import rmj_pkg::*;

	logic err_fields_zero;
	logic range_in_bounds;
	logic no_item;
	logic out_stall;
	logic err_item;
	logic good_item;

	assign err_fields_zero = (range_by_px == '0) && (range_by_py == '0) &&
		(bearing_by_px == '0) && (bearing_by_py == '0) &&
		(rate_by_px == '0) && (rate_by_py == '0);
	assign range_in_bounds = (range_by_px <= 18'sd65536) && (range_by_px >= -18'sd65536) &&
		(range_by_py <= 18'sd65536) && (range_by_py >= -18'sd65536);
	assign no_item   = !jac_valid;
	assign out_stall = jac_valid && !jac_ready;
	assign err_item  = jac_valid && div_error;
	assign good_item = jac_valid && !div_error;

	`RMJ_ASSERT_NXT(a_out_hold, clk, arst_n, out_stall, jac_valid, "output item dropped")
	`RMJ_ASSERT_IMP(a_err_zero, clk, arst_n, err_item, err_fields_zero, "error item not zero")
	`RMJ_ASSERT_IMP(a_range_bnd, clk, arst_n, good_item, range_in_bounds, "range out of bounds")
	`RMJ_ASSERT_IMP(a_in_open, clk, arst_n, no_item, vec_ready, "input stalled, output empty")

endmodule

bind radar_measurement_jacobian_core rmj_chk u_rmj_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.vec_ready     (vec.ready),
	.jac_valid     (jac.valid),
	.jac_ready     (jac.ready),
	.range_by_px   (jac.range_by_px),
	.range_by_py   (jac.range_by_py),
	.bearing_by_px (jac.bearing_by_px),
	.bearing_by_py (jac.bearing_by_py),
	.rate_by_px    (jac.rate_by_px),
	.rate_by_py    (jac.rate_by_py),
	.div_error     (jac.div_error)
);

FILE: sim/radar_measurement_jacobian_core_test.sv
// Self-checking test of radar_measurement_jacobian_core: drives state items, predicts each
// Jacobian item in 128-bit integer arithmetic and compares field by field.
// Depends on rmj_pkg, rmj_if and the core RTL.
module radar_measurement_jacobian_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import rmj_pkg::*;

	typedef struct packed {
		logic [RANGE_W-1:0] range_by_px;
		logic [RANGE_W-1:0] range_by_py;
		logic [VAL_W-1:0] bearing_by_px;
		logic [VAL_W-1:0] bearing_by_py;
		logic [VAL_W-1:0] rate_by_px;
		logic [VAL_W-1:0] rate_by_py;
		logic div_error;
	} jac_t;

	logic clk;
	logic arst_n;
	rmj_cfg_if cfg ();
	rmj_vec_if vec ();
	rmj_jac_if jac ();

	radar_measurement_jacobian_core dut (.clk(clk), .arst_n(arst_n), .cfg(cfg), .vec(vec),
		.jac(jac));

	jac_t jac_pending[$];
	logic [CFG_W-1:0] threshold;
	int mismatches;
	int send_idle;
	int recv_idle;
	longint cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// 128 by 64 divide, clamped to 64 bits
	function automatic logic [63:0] qdiv(input logic [127:0] n, input logic [63:0] d);
		logic [127:0] q;
		q = n / d;
		return (q[127:64] != 0) ? 64'hffff_ffff_ffff_ffff : q[63:0];
	endfunction

	function automatic logic [63:0] clamp(input logic [63:0] m, input logic neg,
			input int w);
		logic [63:0] lim;
		lim = 64'd1 << (w - 1);
		if (m == 0) return 0;
		if (neg) begin
			if (m > lim) m = lim;
			return (64'd0 - m) & ((64'd1 << w) - 1);
		end
		if (m > lim - 1) m = lim - 1;
		return m;
	endfunction

	function automatic jac_t jacobian(input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] vx, input logic [31:0] vy);
		jac_t j;
		logic [63:0] mp, mq, s, s2, r, up, uq, mt, m;
		logic signed [127:0] t;
		logic np, nq, nt;
		int k;
		j = '0;
		np = px[31];
		nq = py[31];
		mp = 64'(mag32(px));
		mq = 64'(mag32(py));
		s = mp * mp + mq * mq;
		if (s == 0 || s < (64'(threshold) << FRAC_BITS)) begin
			j.div_error = 1'b1;
			return j;
		end
		s2 = s;
		k = 0;
		while (s2[63:62] == 0) begin
			s2 <<= 2;
			k++;
		end
		r = isqrt(s2);
		up = qdiv(128'(mp) << (k + 32), r);
		uq = qdiv(128'(mq) << (k + 32), r);
		j.range_by_px = RANGE_W'(clamp(up >> SH, np, RANGE_W));
		j.range_by_py = RANGE_W'(clamp(uq >> SH, nq, RANGE_W));
		j.bearing_by_px = 32'(clamp(qdiv(128'(mq) << (2 * FRAC_BITS), s), !nq, 32));
		j.bearing_by_py = 32'(clamp(qdiv(128'(mp) << (2 * FRAC_BITS), s), np, 32));
		t = 128'(signed'(vx)) * 128'(signed'(py)) - 128'(signed'(vy)) * 128'(signed'(px));
		nt = t < 0;
		mt = nt ? 64'(-t) : 64'(t);
		m = qdiv((128'(uq) * 128'(mt)) >> SH, s);
		j.rate_by_px = 32'(clamp(m, nq != nt, 32));
		m = qdiv((128'(up) * 128'(mt)) >> SH, s);
		j.rate_by_py = 32'(clamp(m, np == nt, 32));
		return j;
	endfunction

	task automatic send_state(input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] vx, input logic [31:0] vy);
		while ($urandom_range(99) < send_idle) begin
			vec.valid <= 1'b0;
			@(posedge clk);
		end
		vec.valid <= 1'b1;
		vec.pos_x <= px;
		vec.pos_y <= py;
		vec.vel_x <= vx;
		vec.vel_y <= vy;
		do @(posedge clk); while (!vec.ready);
		jac_pending.push_back(jacobian(px, py, vx, vy));
	endtask

	task automatic drain;
		vec.valid <= 1'b0;
		while (jac_pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [CFG_W-1:0] v);
		cfg.valid <= 1'b1;
		cfg.min_sq_range <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		threshold = v;
	endtask

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(4))
			0: return $urandom;
			1: return 32'($signed($urandom_range(65535 * 8)) - 65535 * 4);
			2: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
			3: return 32'($signed($urandom_range(2000)) - 1000);
			default: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
		endcase
	endfunction

	task automatic test_directed;
		logic [31:0] ext[6];
		ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff, 32'h0001_0000};
		foreach (ext[a])
			foreach (ext[b])
				if (b % 2 == a % 2) send_state(ext[a], ext[b], ext[b], ext[a]);
		send_state(0, 0, 32'h7fff_ffff, 32'h8000_0000);
		send_state(32'd1500, 32'd1500, 32'h1_0000, 32'hffff_0000);
		send_state(32'h0000_0010, 32'h0, 32'h0, 32'h0);
		send_state(32'h0003_0000, 32'hfffc_0000, 32'h0001_8000, 32'h8000_0000);
	endtask

	task automatic test_random(input int n);
		repeat (n) send_state(rnd_word(), rnd_word(), rnd_word(), rnd_word());
	endtask

	task automatic test_thresholds;
		logic [CFG_W-1:0] levels[4];
		levels = '{16'd0, 16'hffff, 16'd1, 16'd300};
		foreach (levels[i]) begin
			drain();
			write_threshold(levels[i]);
			send_state(0, 0, 32'd5, 32'd5);
			send_state(32'h0000_ffff, 32'h0000_ff00, 32'd5, 32'd5);
			send_state(32'h0001_0000, 0, 32'd5, 32'd5);
			send_state(32'h0100_0000, 32'h00ff_0000, 32'd5, 32'd5);
			test_random(40);
		end
		drain();
		write_threshold(CFG_RESET);
	endtask

	always @(posedge clk) begin
		jac_t got;
		jac_t want;
		if (jac.valid && jac.ready) begin
			got = '{jac.range_by_px, jac.range_by_py, jac.bearing_by_px, jac.bearing_by_py,
				jac.rate_by_px, jac.rate_by_py, jac.div_error};
			if (jac_pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected item %p", got);
			end else begin
				want = jac_pending.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10) $display("expected %p\n  actual %p", want, got);
				end
			end
		end
		jac.ready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		cycles = 0;
		mismatches = 0;
		threshold = CFG_RESET;
		send_idle = 21;
		recv_idle = 69;
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.min_sq_range = '0;
		vec.valid = 1'b0;
		vec.pos_x = '0;
		vec.pos_y = '0;
		vec.vel_x = '0;
		vec.vel_y = '0;
		jac.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300);
		drain();
		send_idle = 69;
		recv_idle = 21;
		test_thresholds();
		test_random(425);
		send_idle = 0;
		recv_idle = 0;
		test_random(425);
		drain();
		if (mismatches == 0 && jac_pending.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
